FILE: src/apd_pkg.sv
// Package for the allpass diffuser chain: sample types, delay lengths and saturation.
package apd_pkg;

    // Sample format and section count.
    localparam int SAMPLE_WIDTH = 24;
    localparam int NUM_STAGES   = 4;

    // Delay line lengths of the sections, first to last.
    localparam int DELAY_ONE   = 579;
    localparam int DELAY_TWO   = 464;
    localparam int DELAY_THREE = 364;
    localparam int DELAY_FOUR  = 248;

    localparam int DELAYS [NUM_STAGES] = '{DELAY_ONE, DELAY_TWO, DELAY_THREE, DELAY_FOUR};

    // Longest line sets the width of the position counters.
    localparam int MAX_DELAY_12 = (DELAY_ONE > DELAY_TWO) ? DELAY_ONE : DELAY_TWO;
    localparam int MAX_DELAY_34 = (DELAY_THREE > DELAY_FOUR) ? DELAY_THREE : DELAY_FOUR;
    localparam int MAX_DELAY    = (MAX_DELAY_12 > MAX_DELAY_34) ? MAX_DELAY_12 : MAX_DELAY_34;
    localparam int POS_W        = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_audio;
    typedef logic signed [SAMPLE_WIDTH:0]   t_wide;
    typedef logic [POS_W-1:0]               t_pos;

    // Request from a cell to its delay line memory.
    typedef struct packed {
        logic    we;
        t_pos    waddr;
        t_audio  wdata;
        logic    re;
        t_pos    raddr;
    } t_mem_req;

    // Clamp a sum that is one bit wider than a sample to the sample range.
    function automatic t_audio sat_sample(input t_wide v);
        t_audio res;
        if (v[SAMPLE_WIDTH] != v[SAMPLE_WIDTH-1]) begin
            res = v[SAMPLE_WIDTH] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end else begin
            res = v[SAMPLE_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

FILE: src/apd_stream_if.sv
// Valid/ready stream interface that carries one sample per beat.
interface apd_stream_if;
    import apd_pkg::*;

    logic    valid;
    logic    ready;
    t_audio  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/apd_ram.sv
// Generic single-write, single-read memory with a registered read port.
module apd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/apd_cell.sv
// One allpass section: position counter, memory sequencing, arithmetic and output register.
module apd_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    apd_stream_if.sink      i_in,
    apd_stream_if.source    o_out,
    input  apd_pkg::t_pos   i_last,
    output apd_pkg::t_mem_req o_mem,
    input  apd_pkg::t_audio   i_rdata
);
    import apd_pkg::*;

    // Control registers.
    t_pos    r_pos, n_pos;
    logic    r_wrap, n_wrap;
    logic    r_a_valid, n_a_valid;
    logic    r_b_valid, n_b_valid;

    // Payload registers of the read stage and the output stage.
    t_audio  r_a_x;
    t_pos    r_a_addr;
    logic    r_a_live;
    logic    r_byp;
    t_audio  r_byp_data;
    t_audio  r_b_y;

    logic    b_free, a_done, a_free, take;
    t_audio  d, half, wdata, y;

    // Handshake between the read stage and the output register.
    always_comb begin
        b_free = !r_b_valid || o_out.ready;
        a_done = r_a_valid && b_free;
        a_free = !r_a_valid || a_done;
        take   = i_in.valid && a_free;
    end

    assign i_in.ready  = a_free;
    assign o_out.valid = r_b_valid;
    assign o_out.data  = r_b_y;

    // Delayed value: forwarded write, stored entry, or zero before the first wrap.
    always_comb begin
        if (r_byp) begin
            d = r_byp_data;
        end else if (r_a_live) begin
            d = i_rdata;
        end else begin
            d = '0;
        end
        half  = d >>> 1;
        wdata = sat_sample(t_wide'(r_a_x) + t_wide'(half));
        y     = sat_sample(t_wide'(d) - t_wide'(r_a_x));
    end

    // Memory request: read on entry, write back when the beat moves on.
    always_comb begin
        o_mem.we    = a_done;
        o_mem.waddr = r_a_addr;
        o_mem.wdata = wdata;
        o_mem.re    = take;
        o_mem.raddr = r_pos;
    end

    // Next-state logic for the control registers.
    always_comb begin
        n_pos     = r_pos;
        n_wrap    = r_wrap;
        n_a_valid = r_a_valid;
        n_b_valid = r_b_valid;
        if (take) begin
            if (r_pos == i_last) begin
                n_pos  = '0;
                n_wrap = 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
        if (take) begin
            n_a_valid = 1'b1;
        end else if (a_done) begin
            n_a_valid = 1'b0;
        end
        if (a_done) begin
            n_b_valid = 1'b1;
        end else if (o_out.ready) begin
            n_b_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_wrap    <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_wrap    <= n_wrap;
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
    end

    // Payload capture; a write to the address being read is forwarded.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_x      <= i_in.data;
            r_a_addr   <= r_pos;
            r_a_live   <= r_wrap;
            r_byp      <= a_done && (r_a_addr == r_pos);
            r_byp_data <= wdata;
        end
        if (a_done) begin
            r_b_y <= y;
        end
    end

    // The position never runs past the last entry of the line.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= i_last)
        else $error("position beyond delay length");

    // Once the line has wrapped, the wrap flag stays set and later reads stay live.
    a_wrap_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrap |=> r_wrap)
        else $error("wrap flag cleared");

    // A forwarded value only ever comes from a line that has wrapped.
    a_byp_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_byp) |-> r_a_live)
        else $error("forwarding before first wrap");

    // A beat that leaves the read stage is registered in the output register with its result.
    a_take_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_done) |=> (r_b_valid && r_b_y == $past(y)))
        else $error("finished beat not registered");

endmodule

FILE: src/allpass_diffuser_chain.sv
// Top level of the four-section allpass diffuser chain.
//
//  channel | dir | payload              | handshake
//  i_in    | in  | data = sample_in     | valid / ready
//  o_out   | out | data = sample_out    | valid / ready
//
// Each section cell takes one beat per cycle unless stalled from the output; in every
// cell a sample passes the memory read stage, then the arithmetic into the output
// register.
// Reset clears positions, wrap flags and valid flags only; a per-cell wrap flag makes the
// delay lines read as zero until first filled, so there is no clearing pass.
// A stall at the output holds each cell's output register and backs ready up
// cell by cell; empty stages still accept beats meanwhile.
module allpass_diffuser_chain (
    input  logic          i_clk,
    input  logic          i_rst_n,
    apd_stream_if.sink    i_in,
    apd_stream_if.source  o_out
);
    import apd_pkg::*;

    apd_stream_if s_link [NUM_STAGES+1] ();

    // Input beat enters the first link, the last link drives the output.
    assign s_link[0].valid = i_in.valid;
    assign s_link[0].data  = i_in.data;
    assign i_in.ready      = s_link[0].ready;

    assign o_out.valid             = s_link[NUM_STAGES].valid;
    assign o_out.data              = s_link[NUM_STAGES].data;
    assign s_link[NUM_STAGES].ready = o_out.ready;

    // Row of section cells, each with its own delay line memory.
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        localparam int AW = (DELAYS[k] > 1) ? $clog2(DELAYS[k]) : 1;

        t_mem_req mem_req;
        t_audio   rdata;

        apd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_in    (s_link[k]),
            .o_out   (s_link[k+1]),
            .i_last  (POS_W'(DELAYS[k] - 1)),
            .o_mem   (mem_req),
            .i_rdata (rdata)
        );

        apd_ram #(
            .WIDTH (SAMPLE_WIDTH),
            .DEPTH (DELAYS[k])
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (mem_req.we),
            .i_waddr (mem_req.waddr[AW-1:0]),
            .i_wdata (mem_req.wdata),
            .i_re    (mem_req.re),
            .i_raddr (mem_req.raddr[AW-1:0]),
            .o_rdata (rdata)
        );
    end

endmodule
